// ===== rtl/vgd_pkg.sv =====
// vgd_pkg: shared types and constants for the voxel grid downsampler
// no dependencies
package vgd_pkg;

   localparam int MaxPointsDef = 64;
   localparam int CsrIdxW = 1;
   localparam int CsrDataW = 23;
   localparam logic [CsrIdxW-1:0] CsrLeafSize = 1'b0;
   localparam logic [CsrIdxW-1:0] CsrUseMedoid = 1'b1;
   localparam logic [22:0] LeafReset = 23'd256;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
      logic in_last;
   } req_type;

   typedef struct packed {
      logic signed [23:0] out_x;
      logic signed [23:0] out_y;
      logic signed [23:0] out_z;
      logic signed [15:0] out_nx;
      logic signed [15:0] out_ny;
      logic signed [15:0] out_nz;
      logic [7:0] out_r;
      logic [7:0] out_g;
      logic [7:0] out_b;
      logic [7:0] out_a;
      logic out_last;
      logic overflow;
   } rsp_type;

   // divider control between sequencer and shared divider
   typedef struct packed {
      logic start;
      logic is_signed;
   } div_ctl_type;

endpackage

// ===== rtl/vgd_div.sv =====
// vgd_div: shared radix-2 restoring divider, one quotient bit per cycle
// depends on vgd_pkg
module vgd_div
   import vgd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_ctl_type ctl,
   input  logic [47:0] dividend,
   input  logic [22:0] divisor,
   output logic        busy,
   output logic [47:0] quotient
);
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] q_ff, q_in;
   logic [23:0] rem_ff, rem_in;
   logic [22:0] d_ff, d_in;
   logic        neg_ff, neg_in;
   logic        busy_ff, busy_in;
   logic [47:0] mag;
   logic [23:0] trial;
   logic [24:0] sub;

   always_comb begin
      mag = (ctl.is_signed && dividend[47]) ? (~dividend + 48'd1) : dividend;
      trial = {rem_ff[22:0], q_ff[47]};
      sub = {1'b0, trial} - {2'b00, d_ff};
      cnt_in = cnt_ff;
      q_in = q_ff;
      rem_in = rem_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      if (ctl.start) begin
         q_in = mag;
         rem_in = '0;
         d_in = divisor;
         neg_in = ctl.is_signed && dividend[47];
         cnt_in = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!sub[24]) begin
            rem_in = sub[23:0];
            q_in = {q_ff[46:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      rem_ff <= rem_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
   end

   assign busy = busy_ff;
   assign quotient = neg_ff ? (~q_ff + 48'd1) : q_ff;
endmodule

// ===== rtl/vgd_isqrt.sv =====
// vgd_isqrt: iterative integer square root, one result bit per cycle
// depends on nothing
module vgd_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [51:0] radicand,
   output logic        busy,
   output logic [25:0] root
);
   logic [51:0] v_ff, v_in;
   logic [51:0] r_ff, r_in;
   logic [51:0] bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic [51:0] trial;

   always_comb begin
      trial = r_ff + bit_ff;
      v_in = v_ff;
      r_in = r_ff;
      bit_in = bit_ff;
      busy_in = busy_ff;
      if (start) begin
         v_in = radicand;
         r_in = '0;
         bit_in = 52'd1 << 50;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 52'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
      v_ff <= v_in;
      r_ff <= r_in;
      bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign root = r_ff[25:0];
endmodule

// ===== rtl/voxel_grid_downsample_top.sv =====
// voxel grid downsampler: one point beat accepted per cycle while loading;
// after the last beat binning divides each point per axis on the shared
// divider, then compares voxel keys; a mean divides per voxel after a scan
// of stored points; a medoid takes a square root per member pair (shared
// square root unit) while scanning point pairs. one result beat per
// voxel through a held output register; sync active-high reset clears the batch
module voxel_grid_downsample_top
   import vgd_pkg::*;
#(
   parameter int MAX_POINTS = MaxPointsDef
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   localparam logic [3:0] S_LOAD = 4'd0, S_BDIV = 4'd1, S_BWAIT = 4'd2,
      S_BSRCH = 4'd3, S_VSCAN = 4'd4, S_MDIV = 4'd5, S_MWAIT = 4'd6,
      S_PI = 4'd7, S_PJ = 4'd8, S_SQW = 4'd9, S_PEND = 4'd10,
      S_OUT = 4'd11, S_RD = 4'd12;

   logic [23:0] sx_mem [MAX_POINTS];
   logic [23:0] sy_mem [MAX_POINTS];
   logic [23:0] sz_mem [MAX_POINTS];
   logic [47:0] sn_mem [MAX_POINTS];
   logic [31:0] sc_mem [MAX_POINTS];
   logic [AW-1:0] vox_mem [MAX_POINTS];
   logic [71:0] key_mem [MAX_POINTS];

   logic [22:0] leaf_ff;
   logic        med_ff;
   logic [3:0]  st_ff;
   logic [23:0] minx_ff, miny_ff, minz_ff;
   logic [CW-1:0] np_ff, nv_ff;
   logic        drop_ff;
   logic [CW-1:0] i_ff, j_ff, v_ff;
   logic [1:0]  ax_ff;
   logic [3:0]  fld_ff;
   logic [71:0] key_ff;
   logic [51:0] acc_ff;
   logic [47:0] sum_ff [10];
   logic [CW-1:0] cnt_ff;
   logic [47:0] res_ff [10];
   logic [51:0] bsum_ff;
   logic [AW-1:0] best_ff;
   logic        found_ff;
   logic        rdv_ff;
   rsp_type     out_ff;
   logic        ov_ff;

   // registered read ports
   logic [AW-1:0] ra_ff, rb_ff;
   logic [23:0] rxa, rya, rza, rxb, ryb, rzb;
   logic [47:0] rna;
   logic [31:0] rca;
   logic [AW-1:0] rva, rvb;
   logic [71:0] rk;

   div_ctl_type dctl;
   logic [47:0] ddiv, dq;
   logic        dbusy;
   logic        sq_start, sq_busy;
   logic [25:0] sq_root;
   logic [51:0] sq_rad;

   logic        acc_in;
   logic [22:0] leaf;
   logic [23:0] diff;
   logic signed [24:0] dxa, dya, dza;
   logic [49:0] sqx, sqy, sqz;

   assign leaf = (leaf_ff == '0) ? 23'd1 : leaf_ff;
   assign acc_in = req_valid && req_ready;
   assign req_ready = (st_ff == S_LOAD);

   vgd_div u_div (
      .clock(clock), .reset(reset), .ctl(dctl), .dividend(ddiv),
      .divisor((st_ff == S_BDIV) ? leaf : {{(23-CW){1'b0}}, cnt_ff}),
      .busy(dbusy), .quotient(dq)
   );

   vgd_isqrt u_sq (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sq_rad),
      .busy(sq_busy), .root(sq_root)
   );

   always_ff @(posedge clock) begin
      rxa <= sx_mem[ra_ff]; rya <= sy_mem[ra_ff]; rza <= sz_mem[ra_ff];
      rna <= sn_mem[ra_ff]; rca <= sc_mem[ra_ff]; rva <= vox_mem[ra_ff];
      rxb <= sx_mem[rb_ff]; ryb <= sy_mem[rb_ff]; rzb <= sz_mem[rb_ff];
      rvb <= vox_mem[rb_ff]; rk <= key_mem[rb_ff];
   end

   always_comb begin
      case (ax_ff)
         2'd0: diff = rxa - minx_ff;
         2'd1: diff = rya - miny_ff;
         default: diff = rza - minz_ff;
      endcase
      dxa = $signed({rxa[23], rxa}) - $signed({rxb[23], rxb});
      dya = $signed({rya[23], rya}) - $signed({ryb[23], ryb});
      dza = $signed({rza[23], rza}) - $signed({rzb[23], rzb});
      sqx = 50'(dxa * dxa);
      sqy = 50'(dya * dya);
      sqz = 50'(dza * dza);
      sq_rad = {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};
      sq_start = (st_ff == S_PJ) && (rvb == v_ff[AW-1:0]) &&
                 (j_ff != i_ff) && (j_ff < np_ff) && rdv_ff;
      dctl.start = 1'b0;
      dctl.is_signed = 1'b0;
      ddiv = {24'd0, diff};
      if (st_ff == S_BDIV && rdv_ff) dctl.start = 1'b1;
      if (st_ff == S_MDIV) begin
         dctl.start = 1'b1;
         dctl.is_signed = (fld_ff < 4'd6);
         ddiv = sum_ff[fld_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_ff <= LeafReset;
         med_ff <= 1'b0;
         st_ff <= S_LOAD;
         minx_ff <= 24'h7fffff; miny_ff <= 24'h7fffff; minz_ff <= 24'h7fffff;
         np_ff <= '0; nv_ff <= '0; drop_ff <= 1'b0;
         rsp_valid <= 1'b0;
         rdv_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CsrLeafSize: leaf_ff <= csr_wdata;
               CsrUseMedoid: med_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         case (st_ff)
            S_LOAD: begin
               if (acc_in) begin
                  if (np_ff < CW'(MAX_POINTS)) begin
                     sx_mem[np_ff[AW-1:0]] <= req_data.x;
                     sy_mem[np_ff[AW-1:0]] <= req_data.y;
                     sz_mem[np_ff[AW-1:0]] <= req_data.z;
                     sn_mem[np_ff[AW-1:0]] <= {req_data.nz, req_data.ny, req_data.nx};
                     sc_mem[np_ff[AW-1:0]] <= {req_data.a, req_data.b, req_data.g,
                                              req_data.r};
                     if (req_data.x < $signed(minx_ff)) minx_ff <= req_data.x;
                     if (req_data.y < $signed(miny_ff)) miny_ff <= req_data.y;
                     if (req_data.z < $signed(minz_ff)) minz_ff <= req_data.z;
                     np_ff <= np_ff + 1'b1;
                  end else begin
                     drop_ff <= 1'b1;
                  end
                  if (req_data.in_last) begin
                     ov_ff <= drop_ff || (np_ff >= CW'(MAX_POINTS));
                     i_ff <= '0; ax_ff <= 2'd0; nv_ff <= '0;
                     ra_ff <= '0; rdv_ff <= 1'b0;
                     st_ff <= S_BDIV;
                  end
               end
            end
            S_BDIV: begin
               if (i_ff == np_ff) begin
                  v_ff <= '0;
                  st_ff <= S_VSCAN;
               end else if (rdv_ff) begin
                  rdv_ff <= 1'b0;
                  st_ff <= S_BWAIT;
               end else begin
                  rdv_ff <= 1'b1;
               end
            end
            S_BWAIT: begin
               if (!dbusy && !dctl.start) begin
                  key_ff <= {dq[23:0], key_ff[71:24]};
                  if (ax_ff == 2'd2) begin
                     ax_ff <= 2'd0;
                     j_ff <= '0; rb_ff <= '0; rdv_ff <= 1'b0;
                     st_ff <= S_BSRCH;
                  end else begin
                     ax_ff <= ax_ff + 2'd1;
                     st_ff <= S_BDIV;
                  end
               end
            end
            S_BSRCH: begin
               if (j_ff == nv_ff) begin
                  key_mem[nv_ff[AW-1:0]] <= key_ff;
                  vox_mem[i_ff[AW-1:0]] <= nv_ff[AW-1:0];
                  nv_ff <= nv_ff + 1'b1;
                  i_ff <= i_ff + 1'b1; ra_ff <= i_ff[AW-1:0] + 1'b1;
                  rdv_ff <= 1'b0;
                  st_ff <= S_BDIV;
               end else if (rdv_ff) begin
                  if (rk == key_ff) begin
                     vox_mem[i_ff[AW-1:0]] <= j_ff[AW-1:0];
                     i_ff <= i_ff + 1'b1; ra_ff <= i_ff[AW-1:0] + 1'b1;
                     rdv_ff <= 1'b0;
                     st_ff <= S_BDIV;
                  end else begin
                     j_ff <= j_ff + 1'b1; rb_ff <= j_ff[AW-1:0] + 1'b1;
                     rdv_ff <= 1'b0;
                  end
               end else begin
                  rdv_ff <= 1'b1;
               end
            end
            S_VSCAN: begin
               // scan members of voxel v
               if (v_ff == nv_ff) begin
                  minx_ff <= 24'h7fffff; miny_ff <= 24'h7fffff;
                  minz_ff <= 24'h7fffff;
                  np_ff <= '0; nv_ff <= '0; drop_ff <= 1'b0;
                  st_ff <= S_LOAD;
               end else begin
                  i_ff <= '0; ra_ff <= '0; rdv_ff <= 1'b0;
                  cnt_ff <= '0; found_ff <= 1'b0;
                  for (int k = 0; k < 10; k++) sum_ff[k] <= '0;
                  st_ff <= med_ff ? S_PI : S_RD;
               end
            end
            S_RD: begin
               if (i_ff == np_ff) begin
                  fld_ff <= '0;
                  st_ff <= S_MDIV;
               end else if (rdv_ff) begin
                  if (rva == v_ff[AW-1:0]) begin
                     sum_ff[0] <= sum_ff[0] + 48'($signed(rxa));
                     sum_ff[1] <= sum_ff[1] + 48'($signed(rya));
                     sum_ff[2] <= sum_ff[2] + 48'($signed(rza));
                     sum_ff[3] <= sum_ff[3] + 48'($signed(rna[15:0]));
                     sum_ff[4] <= sum_ff[4] + 48'($signed(rna[31:16]));
                     sum_ff[5] <= sum_ff[5] + 48'($signed(rna[47:32]));
                     sum_ff[6] <= sum_ff[6] + 48'(rca[7:0]);
                     sum_ff[7] <= sum_ff[7] + 48'(rca[15:8]);
                     sum_ff[8] <= sum_ff[8] + 48'(rca[23:16]);
                     sum_ff[9] <= sum_ff[9] + 48'(rca[31:24]);
                     cnt_ff <= cnt_ff + 1'b1;
                  end
                  i_ff <= i_ff + 1'b1; ra_ff <= i_ff[AW-1:0] + 1'b1;
                  rdv_ff <= 1'b0;
               end else begin
                  rdv_ff <= 1'b1;
               end
            end
            S_MDIV: st_ff <= S_MWAIT;
            S_MWAIT: begin
               if (!dbusy) begin
                  res_ff[fld_ff] <= dq;
                  if (fld_ff == 4'd9) st_ff <= S_OUT;
                  else begin
                     fld_ff <= fld_ff + 4'd1;
                     st_ff <= S_MDIV;
                  end
               end
            end
            S_PI: begin
               if (i_ff == np_ff) begin
                  ra_ff <= best_ff; rdv_ff <= 1'b0;
                  st_ff <= S_PEND;
               end else if (rdv_ff) begin
                  if (rva == v_ff[AW-1:0]) begin
                     j_ff <= '0; rb_ff <= '0; acc_ff <= '0;
                     rdv_ff <= 1'b0;
                     st_ff <= S_PJ;
                  end else begin
                     i_ff <= i_ff + 1'b1; ra_ff <= i_ff[AW-1:0] + 1'b1;
                     rdv_ff <= 1'b0;
                  end
               end else begin
                  rdv_ff <= 1'b1;
               end
            end
            S_PJ: begin
               if (j_ff == np_ff) begin
                  if (!found_ff || acc_ff < bsum_ff) begin
                     found_ff <= 1'b1; bsum_ff <= acc_ff;
                     best_ff <= i_ff[AW-1:0];
                  end
                  i_ff <= i_ff + 1'b1; ra_ff <= i_ff[AW-1:0] + 1'b1;
                  rdv_ff <= 1'b0;
                  st_ff <= S_PI;
               end else if (rdv_ff) begin
                  if (sq_start) st_ff <= S_SQW;
                  j_ff <= j_ff + 1'b1; rb_ff <= j_ff[AW-1:0] + 1'b1;
                  rdv_ff <= 1'b0;
               end else begin
                  rdv_ff <= 1'b1;
               end
            end
            S_SQW: begin
               if (!sq_busy) begin
                  acc_ff <= acc_ff + 52'(sq_root);
                  st_ff <= S_PJ;
               end
            end
            S_PEND: begin
               if (rdv_ff) begin
                  res_ff[0] <= 48'($signed(rxa));
                  res_ff[1] <= 48'($signed(rya));
                  res_ff[2] <= 48'($signed(rza));
                  res_ff[3] <= 48'(rna[15:0]);
                  res_ff[4] <= 48'(rna[31:16]);
                  res_ff[5] <= 48'(rna[47:32]);
                  res_ff[6] <= 48'(rca[7:0]);
                  res_ff[7] <= 48'(rca[15:8]);
                  res_ff[8] <= 48'(rca[23:16]);
                  res_ff[9] <= 48'(rca[31:24]);
                  st_ff <= S_OUT;
               end else begin
                  rdv_ff <= 1'b1;
               end
            end
            S_OUT: begin
               if (!rsp_valid) begin
                  out_ff.out_x <= res_ff[0][23:0];
                  out_ff.out_y <= res_ff[1][23:0];
                  out_ff.out_z <= res_ff[2][23:0];
                  out_ff.out_nx <= res_ff[3][15:0];
                  out_ff.out_ny <= res_ff[4][15:0];
                  out_ff.out_nz <= res_ff[5][15:0];
                  out_ff.out_r <= res_ff[6][7:0];
                  out_ff.out_g <= res_ff[7][7:0];
                  out_ff.out_b <= res_ff[8][7:0];
                  out_ff.out_a <= res_ff[9][7:0];
                  out_ff.out_last <= (v_ff + 1'b1 == nv_ff);
                  out_ff.overflow <= ov_ff;
                  rsp_valid <= 1'b1;
                  v_ff <= v_ff + 1'b1;
                  st_ff <= S_VSCAN;
               end
            end
            default: st_ff <= S_LOAD;
         endcase
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      end
   end

   assign rsp_data = out_ff;

`ifndef SYNTHESIS
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_LOAD) |-> !req_ready) else $error("ready outside load");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      np_ff <= CW'(MAX_POINTS)) else $error("point count over capacity");
   a_vox_le_pts: assert property (@(posedge clock) disable iff (reset)
      nv_ff <= np_ff) else $error("more voxels than points");
`endif
endmodule
